// File: rtl/core/swm_pkg.sv
// swm_pkg: shared types and default sizes for the sliding window median block
// no dependencies; imported by swm_cell, swm_cell_row and sliding_window_median
package swm_pkg;

    localparam int WINDOW_MAX_DEF   = 64;
    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int CFG_WIDTH        = 7;

    // movement of a cell's entry during one update
    typedef struct packed {
        logic up;    // entry moves to the next higher cell
        logic down;  // entry moves to the next lower cell
    } swm_move_t;

endpackage

// File: rtl/core/swm_cell.sv
// swm_cell: one slot of the sorted window, holding a sample and its age
// depends on swm_pkg (swm_move_t)
module swm_cell #(
    parameter int SAMPLE_WIDTH = 32,
    parameter int AGE_W        = 6
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic [SAMPLE_WIDTH-1:0]   x,
    input  logic                      valid,
    input  logic                      full,
    input  logic [AGE_W-1:0]          oldest_age,
    input  logic                      rm_below,
    input  logic [SAMPLE_WIDTH-1:0]   left_val,
    input  logic [AGE_W-1:0]          left_age,
    input  swm_pkg::swm_move_t        left_move,
    input  logic [SAMPLE_WIDTH-1:0]   right_val,
    input  logic [AGE_W-1:0]          right_age,
    input  swm_pkg::swm_move_t        right_move,
    output logic [SAMPLE_WIDTH-1:0]   val,
    output logic [AGE_W-1:0]          age,
    output swm_pkg::swm_move_t        move,
    output logic                      rm
);
    import swm_pkg::*;

    logic [SAMPLE_WIDTH-1:0] val_reg;
    logic [SAMPLE_WIDTH-1:0] val_next;
    logic [AGE_W-1:0]        age_reg;
    logic [AGE_W-1:0]        age_next;
    logic                    gt;
    logic                    stay;

    // empty slots count as larger than any sample
    assign gt   = !valid || ($signed(val_reg) > $signed(x));
    assign rm   = full && valid && (age_reg == oldest_age);
    assign stay = (rm_below == gt) && !rm;

    assign move.up   = !rm_below && gt && !rm;
    assign move.down = rm_below && !gt;

    always_comb
    begin
        if (right_move.down)
        begin
            val_next = right_val;
            age_next = right_age + AGE_W'(1);
        end
        else if (left_move.up)
        begin
            val_next = left_val;
            age_next = left_age + AGE_W'(1);
        end
        else if (stay)
        begin
            val_next = val_reg;
            age_next = age_reg + AGE_W'(1);
        end
        else
        begin
            val_next = x;
            age_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            val_reg <= val_next;
            age_reg <= age_next;
        end
    end

    assign val = val_reg;
    assign age = age_reg;

endmodule

// File: rtl/core/swm_cell_row.sv
// swm_cell_row: row of swm_cell slots kept in ascending order, plus median tap
// depends on swm_pkg and swm_cell
module swm_cell_row #(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 32,
    parameter int FILL_W       = 7,
    parameter int AGE_W        = 6
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic [SAMPLE_WIDTH-1:0] x,
    input  logic [FILL_W-1:0]       fill,
    input  logic                    full,
    input  logic [AGE_W-1:0]        oldest_age,
    input  logic [AGE_W-1:0]        mid,
    output logic [SAMPLE_WIDTH-1:0] median
);
    import swm_pkg::*;

    logic [SAMPLE_WIDTH-1:0] val_vec  [WINDOW_MAX];
    logic [AGE_W-1:0]        age_vec  [WINDOW_MAX];
    swm_move_t               move_vec [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]   rm_vec;
    logic [WINDOW_MAX-1:0]   below_vec;
    logic [WINDOW_MAX-1:0]   valid_vec;

    genvar i;
    generate
        for (i = 0; i < WINDOW_MAX; i++)
        begin : g_cell
            logic [SAMPLE_WIDTH-1:0] lv;
            logic [AGE_W-1:0]        la;
            swm_move_t               lm;
            logic [SAMPLE_WIDTH-1:0] rv;
            logic [AGE_W-1:0]        ra;
            swm_move_t               rmv;

            assign valid_vec[i] = FILL_W'(i) < fill;

            if (i == 0)
            begin : g_first
                assign below_vec[i] = 1'b0;
                assign lv = '0;
                assign la = '0;
                assign lm = '0;
            end
            else
            begin : g_mid
                // an entry removed lower down pulls this one down a slot
                assign below_vec[i] = |rm_vec[i-1:0];
                assign lv = val_vec[i-1];
                assign la = age_vec[i-1];
                assign lm = move_vec[i-1];
            end

            if (i == WINDOW_MAX - 1)
            begin : g_last
                assign rv  = '0;
                assign ra  = '0;
                assign rmv = '0;
            end
            else
            begin : g_notlast
                assign rv  = val_vec[i+1];
                assign ra  = age_vec[i+1];
                assign rmv = move_vec[i+1];
            end

            swm_cell #(
                .SAMPLE_WIDTH (SAMPLE_WIDTH),
                .AGE_W        (AGE_W)
            ) u_cell (
                .clk        (clk),
                .en         (en),
                .x          (x),
                .valid      (valid_vec[i]),
                .full       (full),
                .oldest_age (oldest_age),
                .rm_below   (below_vec[i]),
                .left_val   (lv),
                .left_age   (la),
                .left_move  (lm),
                .right_val  (rv),
                .right_age  (ra),
                .right_move (rmv),
                .val        (val_vec[i]),
                .age        (age_vec[i]),
                .move       (move_vec[i]),
                .rm         (rm_vec[i])
            );
        end
    endgenerate

    // and-or tap at the median slot
    always_comb
    begin
        median = '0;
        for (int j = 0; j < WINDOW_MAX; j++)
        begin
            if (AGE_W'(j) == mid)
            begin
                median = median | val_vec[j];
            end
        end
    end

`ifndef SYNTH
    // at most one slot holds the oldest sample
    a_one_removal: assert property (@(posedge clk) en |-> $onehot0(rm_vec))
        else $error("more than one slot marked for removal");
    // a full window always drops exactly one sample
    a_full_removes: assert property (@(posedge clk)
        (en && full && (fill != '0)) |-> $onehot(rm_vec))
        else $error("full window without a removal");
`endif

endmodule

// File: rtl/core/sliding_window_median.sv
// sliding_window_median: top level of the running median filter
// depends on swm_pkg and swm_cell_row (which instantiates swm_cell)
//
// usage:
//   input stream s_*: one signed sample per item in s_tdata, s_tuser[0] is the
//   stream start flag that empties the window before that sample goes in
//   output stream m_*: the lower median of the last window_size samples, one
//   item per input item once the window is full, none while it is filling
//   cfg_*: writes window_size (0 acts as 1, values above WINDOW_MAX saturate);
//   a write also empties the window; only to be written while the block is idle
// throughput: one item per cycle while the output is not stalled, set by the cell
//   row which inserts the new sample and drops the oldest one in a single update of every cell
// output path: the cells update at the accepting edge; the median tap then
//   loads the output register once it is free, which raises m_tvalid
// reset: window_size returns to 1 and the window is empty; cell contents are
//   not cleared, slots above the fill count are never read
// stall: a low m_tready keeps the result in the output register; one more
//   result may wait behind it, after which s_tready drops
module sliding_window_median #(
    parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_tdata,   // [SAMPLE_WIDTH-1:0] sample
    input  logic [0:0]                          s_tuser,   // [0] stream_start
    // output stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   m_tdata,   // [SAMPLE_WIDTH-1:0] median
    // configuration write
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [swm_pkg::CFG_WIDTH-1:0]       cfg_data   // window_size
);
    import swm_pkg::*;

    localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int FILL_W  = $clog2(WINDOW_MAX + 1);
    localparam int AGE_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int KW      = (FILL_W > CFG_WIDTH) ? FILL_W : CFG_WIDTH;

    logic [CFG_WIDTH-1:0]    wsize_reg;
    logic [FILL_W-1:0]       fill_reg;
    logic [FILL_W-1:0]       fill_next;
    logic                    pend_reg;      // result waiting for the median tap
    logic                    m_valid_reg;
    logic [SAMPLE_WIDTH-1:0] m_data_reg;

    logic [KW-1:0]           wsize_wide;
    logic [FILL_W-1:0]       k_eff;
    logic [FILL_W-1:0]       fill_base;
    logic                    full;
    logic                    in_fire;
    logic                    out_free;
    logic                    result;
    logic [AGE_W-1:0]        oldest_age;
    logic [AGE_W-1:0]        mid;
    logic [SAMPLE_WIDTH-1:0] sample;
    logic [SAMPLE_WIDTH-1:0] median;

    // effective window length
    assign wsize_wide = KW'(wsize_reg);
    always_comb
    begin
        if (wsize_reg == '0)
        begin
            k_eff = FILL_W'(1);
        end
        else if (wsize_wide > KW'(WINDOW_MAX))
        begin
            k_eff = FILL_W'(WINDOW_MAX);
        end
        else
        begin
            k_eff = FILL_W'(wsize_wide);
        end
    end

    assign oldest_age = AGE_W'(k_eff - FILL_W'(1));
    assign mid        = AGE_W'((k_eff - FILL_W'(1)) >> 1);

    assign sample   = s_tdata[SAMPLE_WIDTH-1:0];
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = !pend_reg || out_free;
    assign in_fire  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // stream start, or a stale count, empties the window first
    assign fill_base = (s_tuser[0] || (fill_reg > k_eff)) ? '0 : fill_reg;
    assign full      = (fill_base == k_eff);
    assign fill_next = full ? k_eff : fill_base + FILL_W'(1);
    assign result    = (fill_next == k_eff);

    swm_cell_row #(
        .WINDOW_MAX   (WINDOW_MAX),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .FILL_W       (FILL_W),
        .AGE_W        (AGE_W)
    ) u_row (
        .clk        (clk),
        .en         (in_fire),
        .x          (sample),
        .fill       (fill_base),
        .full       (full),
        .oldest_age (oldest_age),
        .mid        (mid),
        .median     (median)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wsize_reg   <= CFG_WIDTH'(1);
            fill_reg    <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                wsize_reg <= cfg_data;
                fill_reg  <= '0;
            end
            else if (in_fire)
            begin
                fill_reg <= fill_next;
            end

            // median tap reads the cells after their update, once the output register is free
            if (pend_reg && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            if (in_fire)
            begin
                pend_reg <= result;
            end
            else if (out_free)
            begin
                pend_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg && out_free)
        begin
            m_data_reg <= median;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDATA_W'(m_data_reg);

`ifndef SYNTH
    // a waiting result behind a stalled output blocks new items
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && m_valid_reg && !m_tready) |-> !s_tready)
        else $error("input taken while both result slots are busy");
    // the fill count never exceeds the window length
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= k_eff)
        else $error("fill count above window length");
    // a stream start leaves exactly one sample in the window
    a_start_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_tuser[0] && !cfg_valid) |=> (fill_reg == FILL_W'(1)))
        else $error("stream start did not restart the window");
`endif

endmodule
